/* src/quaternion_blend_to_matrix_assert.svh */
// Assertion macros shared by the quaternion blend RTL.
// Define ASSERT_OFF to compile every check out.
`ifndef QUATERNION_BLEND_TO_MATRIX_ASSERT_SVH
`define QUATERNION_BLEND_TO_MATRIX_ASSERT_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define QBM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define QBM_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define QBM_ASSERT(lbl, clk, rstn, prop, msg)
`define QBM_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

/* src/qbm_pkg.sv */
`default_nettype none

package qbm_pkg;

    // Fixed-point constants
    localparam logic [16:0] BLEND_ONE   = 17'd65536;
    localparam logic [63:0] NORM_MIN_SQ = 64'd7205760;
    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [28:0] OUT_MAX = 29'sd8388607;
    localparam logic signed [28:0] OUT_MIN = -29'sd8388608;
    localparam logic signed [15:0] UNIT_Q14 = 16'sd16384;
    localparam logic [14:0] QUOT_MAX = 15'd16391;

    // Pipeline depths of the root and divide units
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 15;

    // Payload that rides along the square root unit
    typedef struct packed {
        logic [3:0][31:0] q;     // blended quaternion, signed Q28
        logic [2:0][15:0] scl;   // row scales, signed Q8.8
        logic             deg;   // norm below threshold
    } sq_side_t;

    // Payload that rides along the divide unit
    typedef struct packed {
        logic [2:0][15:0] scl;
        logic             deg;
        logic [3:0]       neg;   // sign of each quaternion lane
    } div_side_t;

endpackage

`default_nettype wire

/* src/qbm_sqrt.sv */
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module qbm_sqrt import qbm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] in_rad,
    input  wire sq_side_t    in_side,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [30:0]      out_root,
    output sq_side_t         out_side
);

    logic        v_reg    [SQRT_STAGES];
    logic [63:0] rad_reg  [SQRT_STAGES];
    logic [63:0] res_reg  [SQRT_STAGES];
    sq_side_t    side_reg [SQRT_STAGES];
    logic        en       [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BITC = 64'd1 << (62 - 2 * k);
        logic        vi;
        logic [63:0] ri, si, trial;
        sq_side_t    di;

        // stage input: port for the first stage, previous stage otherwise
        if (k == 0) begin : g_first
            assign vi = in_valid;
            assign ri = in_rad;
            assign si = '0;
            assign di = in_side;
        end else begin : g_mid
            assign vi = v_reg[k-1];
            assign ri = rad_reg[k-1];
            assign si = res_reg[k-1];
            assign di = side_reg[k-1];
        end

        // stage advances when empty or when the next one takes its word
        if (k == SQRT_STAGES - 1) begin : g_last
            assign en[k] = !v_reg[k] || out_ready;
        end else begin : g_inner
            assign en[k] = !v_reg[k] || en[k+1];
        end

        assign trial = si + BITC;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en[k]) begin
                v_reg[k] <= vi;
            end
        end

        // one restoring root step
        always_ff @(posedge aclk) begin
            if (en[k] && vi) begin
                side_reg[k] <= di;
                if (ri >= trial) begin
                    rad_reg[k] <= ri - trial;
                    res_reg[k] <= (si >> 1) + BITC;
                end else begin
                    rad_reg[k] <= ri;
                    res_reg[k] <= si >> 1;
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = res_reg[SQRT_STAGES-1][30:0];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

`default_nettype wire

/* src/qbm_div.sv */
`default_nettype none

// Four-lane pipelined restoring divider, one quotient bit per stage.
module qbm_div import qbm_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [3:0][45:0] in_num,
    input  wire logic [30:0]      in_den,
    input  wire div_side_t        in_side,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [3:0][14:0]      out_quot,
    output div_side_t             out_side
);

    logic                  v_reg    [DIV_STAGES];
    logic [3:0][45:0]      rem_reg  [DIV_STAGES];
    logic [3:0][14:0]      quot_reg [DIV_STAGES];
    logic [30:0]           den_reg  [DIV_STAGES];
    div_side_t             side_reg [DIV_STAGES];
    logic                  en       [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        localparam int SH = DIV_STAGES - 1 - j;
        logic             vi;
        logic [3:0][45:0] ri;
        logic [3:0][14:0] qi;
        logic [30:0]      di;
        div_side_t        si;
        logic [45:0]      dk;

        if (j == 0) begin : g_first
            assign vi = in_valid;
            assign ri = in_num;
            assign qi = '0;
            assign di = in_den;
            assign si = in_side;
        end else begin : g_mid
            assign vi = v_reg[j-1];
            assign ri = rem_reg[j-1];
            assign qi = quot_reg[j-1];
            assign di = den_reg[j-1];
            assign si = side_reg[j-1];
        end

        if (j == DIV_STAGES - 1) begin : g_last
            assign en[j] = !v_reg[j] || out_ready;
        end else begin : g_inner
            assign en[j] = !v_reg[j] || en[j+1];
        end

        // divisor aligned to this quotient bit
        assign dk = 46'(di) << SH;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en[j]) begin
                v_reg[j] <= vi;
            end
        end

        // trial subtract on every lane
        always_ff @(posedge aclk) begin
            if (en[j] && vi) begin
                den_reg[j]  <= di;
                side_reg[j] <= si;
                for (int l = 0; l < 4; l++) begin
                    if (ri[l] >= dk) begin
                        rem_reg[j][l]  <= ri[l] - dk;
                        quot_reg[j][l] <= {qi[l][13:0], 1'b1};
                    end else begin
                        rem_reg[j][l]  <= ri[l];
                        quot_reg[j][l] <= {qi[l][13:0], 1'b0};
                    end
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_quot  = quot_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

/* src/quaternion_blend_to_matrix.sv */
// Keyframe quaternion blend to a scaled 3x3 rotation matrix.
// Input channel s_*: one word carries both keyframe quaternions (Q1.14), the
// blend factor (Q1.16, clamped to one) and three row scales (Q8.8).
// Output channel m_*: nine Q9.14 matrix elements in row-major order on
// m_tdata, and the degenerate flag on m_tuser (identity was used because the
// blended norm fell below 0.00001).
// Throughput: one word per clock, sustained, when the receiver keeps up.
// Pipeline: the blend and norm stages, the 32-stage square root (one root
// bit per stage), the 15-stage divider (one quotient bit per stage) and the
// matrix stages.
// Every stage carries its own valid bit; a stage loads whenever it is empty or
// its successor loads, so bubbles close up while the output is stalled.
// When m_tready is low the result holds on m_tdata and the pipeline keeps
// filling; s_tready drops only once every stage holds a word.
// Reset (aresetn low, synchronous) empties all stages; data is not cleared.
`default_nettype none
`include "quaternion_blend_to_matrix_assert.svh"

module quaternion_blend_to_matrix import qbm_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // quat_a_x, quat_a_y, quat_a_z, quat_a_w, quat_b_x, quat_b_y, quat_b_z,
    // quat_b_w, blend_factor, scale_x, scale_y, scale_z, zero pad
    input  wire logic [199:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
    output logic [215:0]      m_tdata,
    // degenerate
    output logic              m_tuser
);

    // stage enables
    logic en_p1, en_p2, en_p3, en_p4, en_p5, en_p6, en_p7;
    logic en_m1, en_m2, en_m3, en_m4, en_out;
    logic sqrt_in_ready, sqrt_out_valid, div_in_ready, div_out_valid;

    logic p1_v_reg, p2_v_reg, p3_v_reg, p4_v_reg, p5_v_reg, p6_v_reg, p7_v_reg;
    logic m1_v_reg, m2_v_reg, m3_v_reg, m4_v_reg, m_tvalid_reg;

    assign en_out = !m_tvalid_reg || m_tready;
    assign en_m4  = !m4_v_reg || en_out;
    assign en_m3  = !m3_v_reg || en_m4;
    assign en_m2  = !m2_v_reg || en_m3;
    assign en_m1  = !m1_v_reg || en_m2;
    assign en_p7  = !p7_v_reg || div_in_ready;
    assign en_p6  = !p6_v_reg || sqrt_in_ready;
    assign en_p5  = !p5_v_reg || en_p6;
    assign en_p4  = !p4_v_reg || en_p5;
    assign en_p3  = !p3_v_reg || en_p4;
    assign en_p2  = !p2_v_reg || en_p3;
    assign en_p1  = !p1_v_reg || en_p2;
    assign s_tready = en_p1;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0; p2_v_reg <= 1'b0; p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0; p5_v_reg <= 1'b0; p6_v_reg <= 1'b0;
            p7_v_reg <= 1'b0; m1_v_reg <= 1'b0; m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0; m4_v_reg <= 1'b0; m_tvalid_reg <= 1'b0;
        end else begin
            if (en_p1)  p1_v_reg <= s_tvalid;
            if (en_p2)  p2_v_reg <= p1_v_reg;
            if (en_p3)  p3_v_reg <= p2_v_reg;
            if (en_p4)  p4_v_reg <= p3_v_reg;
            if (en_p5)  p5_v_reg <= p4_v_reg;
            if (en_p6)  p6_v_reg <= p5_v_reg;
            if (en_p7)  p7_v_reg <= sqrt_out_valid;
            if (en_m1)  m1_v_reg <= div_out_valid;
            if (en_m2)  m2_v_reg <= m1_v_reg;
            if (en_m3)  m3_v_reg <= m2_v_reg;
            if (en_m4)  m4_v_reg <= m3_v_reg;
            if (en_out) m_tvalid_reg <= m4_v_reg;
        end
    end

    // input word unpack
    logic signed [15:0] in_a [4];
    logic signed [15:0] in_b [4];
    logic signed [15:0] in_s [3];
    logic        [16:0] in_t;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_a[i] = s_tdata[16*i +: 16];
            in_b[i] = s_tdata[64 + 16*i +: 16];
        end
        for (int i = 0; i < 3; i++) begin
            in_s[i] = s_tdata[145 + 16*i +: 16];
        end
        in_t = s_tdata[144:128];
    end

    // P1: register inputs, lane products for the dot product, clamp blend
    logic signed [15:0] p1_a_reg [4];
    logic signed [15:0] p1_b_reg [4];
    logic signed [31:0] p1_ab_reg [4];
    logic signed [15:0] p1_s_reg [3];
    logic        [16:0] p1_t_reg;

    always_ff @(posedge aclk) begin
        if (en_p1 && s_tvalid) begin
            for (int i = 0; i < 4; i++) begin
                p1_a_reg[i]  <= in_a[i];
                p1_b_reg[i]  <= in_b[i];
                p1_ab_reg[i] <= 32'(in_a[i]) * 32'(in_b[i]);
            end
            p1_s_reg <= in_s;
            p1_t_reg <= (in_t > BLEND_ONE) ? BLEND_ONE : in_t;
        end
    end

    // P2: dot sign picks the short path, then lane differences
    logic signed [33:0] dot;
    logic signed [16:0] an [4];
    logic signed [16:0] p2_an_reg [4];
    logic signed [17:0] p2_diff_reg [4];
    logic signed [15:0] p2_s_reg [3];
    logic        [16:0] p2_t_reg;

    always_comb begin
        dot = 34'(p1_ab_reg[0]) + 34'(p1_ab_reg[1]) + 34'(p1_ab_reg[2]) + 34'(p1_ab_reg[3]);
        for (int i = 0; i < 4; i++) begin
            an[i] = dot[33] ? -17'(p1_a_reg[i]) : 17'(p1_a_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p2 && p1_v_reg) begin
            for (int i = 0; i < 4; i++) begin
                p2_an_reg[i]   <= an[i];
                p2_diff_reg[i] <= 18'(p1_b_reg[i]) - 18'(an[i]);
            end
            p2_s_reg <= p1_s_reg;
            p2_t_reg <= p1_t_reg;
        end
    end

    // P3: linear blend in Q30
    logic signed [17:0] t_s;
    logic signed [35:0] p3_q30_reg [4];
    logic signed [15:0] p3_s_reg [3];

    assign t_s = {1'b0, p2_t_reg};

    always_ff @(posedge aclk) begin
        if (en_p3 && p2_v_reg) begin
            for (int i = 0; i < 4; i++) begin
                p3_q30_reg[i] <= (36'(p2_an_reg[i]) <<< 16) + 36'(t_s) * 36'(p2_diff_reg[i]);
            end
            p3_s_reg <= p2_s_reg;
        end
    end

    // P4: round Q30 to Q28, ties away from zero
    logic        [35:0] q_mag [4];
    logic        [33:0] q_rnd [4];
    logic signed [31:0] q_val [4];
    logic signed [31:0] p4_q_reg [4];
    logic signed [15:0] p4_s_reg [3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            q_mag[i] = p3_q30_reg[i][35] ? 36'(-p3_q30_reg[i]) : 36'(p3_q30_reg[i]);
            q_rnd[i] = 34'((q_mag[i] + 36'd2) >> 2);
            q_val[i] = p3_q30_reg[i][35] ? -32'(q_rnd[i]) : 32'(q_rnd[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p4 && p3_v_reg) begin
            p4_q_reg <= q_val;
            p4_s_reg <= p3_s_reg;
        end
    end

    // P5: lane squares
    logic [63:0]        p5_sq_reg [4];
    logic signed [31:0] p5_q_reg [4];
    logic signed [15:0] p5_s_reg [3];

    always_ff @(posedge aclk) begin
        if (en_p5 && p4_v_reg) begin
            for (int i = 0; i < 4; i++) begin
                p5_sq_reg[i] <= 64'(64'(p4_q_reg[i]) * 64'(p4_q_reg[i]));
            end
            p5_q_reg <= p4_q_reg;
            p5_s_reg <= p4_s_reg;
        end
    end

    // P6: squared norm and threshold test
    logic [63:0] norm_sq;
    logic [63:0] p6_n_reg;
    sq_side_t    p6_side_reg;

    assign norm_sq = p5_sq_reg[0] + p5_sq_reg[1] + p5_sq_reg[2] + p5_sq_reg[3];

    always_ff @(posedge aclk) begin
        if (en_p6 && p5_v_reg) begin
            p6_n_reg <= norm_sq;
            for (int i = 0; i < 4; i++) begin
                p6_side_reg.q[i] <= p5_q_reg[i];
            end
            for (int i = 0; i < 3; i++) begin
                p6_side_reg.scl[i] <= p5_s_reg[i];
            end
            p6_side_reg.deg <= norm_sq < NORM_MIN_SQ;
        end
    end

    // square root of the norm
    logic [30:0] root;
    sq_side_t    sqrt_side;

    qbm_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p6_v_reg),
        .in_ready  (sqrt_in_ready),
        .in_rad    (p6_n_reg),
        .in_side   (p6_side_reg),
        .out_valid (sqrt_out_valid),
        .out_ready (en_p7),
        .out_root  (root),
        .out_side  (sqrt_side)
    );

    // P7: dividends with the rounding half of the divisor folded in
    logic signed [31:0] qs [4];
    logic        [31:0] qa [4];
    logic [3:0][45:0]   p7_num_reg;
    logic [30:0]        p7_den_reg;
    div_side_t          p7_side_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qs[i] = $signed(sqrt_side.q[i]);
            qa[i] = qs[i][31] ? 32'(-qs[i]) : 32'(qs[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p7 && sqrt_out_valid) begin
            for (int i = 0; i < 4; i++) begin
                p7_num_reg[i]      <= (46'(qa[i]) << 14) + 46'(root >> 1);
                p7_side_reg.neg[i] <= qs[i][31];
            end
            p7_den_reg      <= root;
            p7_side_reg.scl <= sqrt_side.scl;
            p7_side_reg.deg <= sqrt_side.deg;
        end
    end

    // normalize each lane
    logic [3:0][14:0] quot;
    div_side_t        div_side;

    qbm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p7_v_reg),
        .in_ready  (div_in_ready),
        .in_num    (p7_num_reg),
        .in_den    (p7_den_reg),
        .in_side   (p7_side_reg),
        .out_valid (div_out_valid),
        .out_ready (en_m1),
        .out_quot  (quot),
        .out_side  (div_side)
    );

    // M1: signed unit quaternion, identity when degenerate
    logic signed [15:0] m1_u_reg [4];
    logic signed [15:0] m1_s_reg [3];
    logic               m1_deg_reg;

    always_ff @(posedge aclk) begin
        if (en_m1 && div_out_valid) begin
            for (int i = 0; i < 4; i++) begin
                if (div_side.deg) begin
                    m1_u_reg[i] <= (i == 3) ? UNIT_Q14 : 16'sd0;
                end else begin
                    m1_u_reg[i] <= div_side.neg[i] ? -16'(quot[i]) : 16'(quot[i]);
                end
            end
            for (int i = 0; i < 3; i++) begin
                m1_s_reg[i] <= $signed(div_side.scl[i]);
            end
            m1_deg_reg <= div_side.deg;
        end
    end

    // M2: pairwise products xx yy zz xy xz yz xw yw zw
    logic signed [31:0] m2_p_reg [9];
    logic signed [15:0] m2_s_reg [3];
    logic               m2_deg_reg;

    always_ff @(posedge aclk) begin
        if (en_m2 && m1_v_reg) begin
            m2_p_reg[0] <= 32'(m1_u_reg[0]) * 32'(m1_u_reg[0]);
            m2_p_reg[1] <= 32'(m1_u_reg[1]) * 32'(m1_u_reg[1]);
            m2_p_reg[2] <= 32'(m1_u_reg[2]) * 32'(m1_u_reg[2]);
            m2_p_reg[3] <= 32'(m1_u_reg[0]) * 32'(m1_u_reg[1]);
            m2_p_reg[4] <= 32'(m1_u_reg[0]) * 32'(m1_u_reg[2]);
            m2_p_reg[5] <= 32'(m1_u_reg[1]) * 32'(m1_u_reg[2]);
            m2_p_reg[6] <= 32'(m1_u_reg[0]) * 32'(m1_u_reg[3]);
            m2_p_reg[7] <= 32'(m1_u_reg[1]) * 32'(m1_u_reg[3]);
            m2_p_reg[8] <= 32'(m1_u_reg[2]) * 32'(m1_u_reg[3]);
            m2_s_reg   <= m1_s_reg;
            m2_deg_reg <= m1_deg_reg;
        end
    end

    // M3: rotation matrix in Q28
    logic signed [33:0] pe [9];
    logic signed [33:0] m3_r_reg [9];
    logic signed [15:0] m3_s_reg [3];
    logic               m3_deg_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            pe[i] = 34'(m2_p_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en_m3 && m2_v_reg) begin
            m3_r_reg[0] <= ONE_Q28 - ((pe[1] + pe[2]) <<< 1);
            m3_r_reg[1] <= (pe[3] - pe[8]) <<< 1;
            m3_r_reg[2] <= (pe[4] + pe[7]) <<< 1;
            m3_r_reg[3] <= (pe[3] + pe[8]) <<< 1;
            m3_r_reg[4] <= ONE_Q28 - ((pe[0] + pe[2]) <<< 1);
            m3_r_reg[5] <= (pe[5] - pe[6]) <<< 1;
            m3_r_reg[6] <= (pe[4] - pe[7]) <<< 1;
            m3_r_reg[7] <= (pe[5] + pe[6]) <<< 1;
            m3_r_reg[8] <= ONE_Q28 - ((pe[0] + pe[1]) <<< 1);
            m3_s_reg   <= m2_s_reg;
            m3_deg_reg <= m2_deg_reg;
        end
    end

    // M4: row scaling, Q36
    logic signed [49:0] m4_rs_reg [9];
    logic               m4_deg_reg;

    always_ff @(posedge aclk) begin
        if (en_m4 && m3_v_reg) begin
            for (int row = 0; row < 3; row++) begin
                for (int col = 0; col < 3; col++) begin
                    m4_rs_reg[row*3 + col] <= 50'(m3_r_reg[row*3 + col]) * 50'(m3_s_reg[row]);
                end
            end
            m4_deg_reg <= m3_deg_reg;
        end
    end

    // output register: round to Q14 and saturate to 24 bits
    logic        [49:0] rs_mag [9];
    logic        [27:0] rs_rnd [9];
    logic signed [28:0] rs_val [9];
    logic signed [28:0] rs_sat [9];
    logic [215:0]       m_tdata_reg;
    logic               m_tuser_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            rs_mag[i] = m4_rs_reg[i][49] ? 50'(-m4_rs_reg[i]) : 50'(m4_rs_reg[i]);
            rs_rnd[i] = 28'((rs_mag[i] + 50'd2097152) >> 22);
            rs_val[i] = m4_rs_reg[i][49] ? -29'(rs_rnd[i]) : 29'(rs_rnd[i]);
            if (rs_val[i] > OUT_MAX) begin
                rs_sat[i] = OUT_MAX;
            end else if (rs_val[i] < OUT_MIN) begin
                rs_sat[i] = OUT_MIN;
            end else begin
                rs_sat[i] = rs_val[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && m4_v_reg) begin
            for (int i = 0; i < 9; i++) begin
                m_tdata_reg[24*i +: 24] <= rs_sat[i][23:0];
            end
            m_tuser_reg <= m4_deg_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `QBM_ASSERT(a_deg_diag, aclk, aresetn, (m_tvalid_reg && m_tuser_reg) |-> (m_tdata_reg[47:24] == 24'd0 && m_tdata_reg[71:48] == 24'd0 && m_tdata_reg[95:72] == 24'd0 && m_tdata_reg[143:120] == 24'd0 && m_tdata_reg[167:144] == 24'd0 && m_tdata_reg[191:168] == 24'd0), "degenerate result has off-diagonal terms")
    `QBM_ASSERT(a_backpressure, aclk, aresetn, !en_p1 |-> (m_tvalid_reg && !m_tready), "input stalled while output drains")
    `QBM_ASSERT(a_quot_bound, aclk, aresetn, (div_out_valid && !div_side.deg) |-> (quot[0] <= QUOT_MAX && quot[1] <= QUOT_MAX && quot[2] <= QUOT_MAX && quot[3] <= QUOT_MAX), "normalized lane out of range")

endmodule

`default_nettype wire

/* verif/quaternion_blend_to_matrix_checker.sv */
`default_nettype none

module quaternion_blend_to_matrix_checker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [199:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [215:0] m_tdata,
    input  wire logic         m_tuser,
    output int                fail_count,
    output int                pending,
    output int                matrices_seen,
    output int                degenerate_seen
);

    typedef struct packed {
        logic [8:0][23:0] elem;
        logic             degen;
    } matrix_t;

    matrix_t expected_matrices[$];

    // round to nearest, ties away from zero
    function automatic longint round_shift(longint v, int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (longint'(1) << (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint round_div(longint num, longint den);
        longint m;
        m = (num < 0) ? -num : num;
        m = (m + den / 2) / den;
        return (num < 0) ? -m : m;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic matrix_t blend_to_matrix(logic [199:0] w);
        longint a[4], b[4], q[4], u[4], s[3], r[9];
        longint dot, t, v, x, y, z, ww;
        longint unsigned n;
        matrix_t res;
        dot = 0;
        n = 0;
        t = longint'(w[143:128]) | (longint'(w[144]) << 16);
        if (t > 65536) t = 65536;
        for (int i = 0; i < 4; i++) begin
            a[i] = longint'($signed(w[16*i +: 16]));
            b[i] = longint'($signed(w[64 + 16*i +: 16]));
            dot += a[i] * b[i];
        end
        for (int i = 0; i < 3; i++) s[i] = longint'($signed(w[145 + 16*i +: 16]));
        if (dot < 0)
            for (int i = 0; i < 4; i++) a[i] = -a[i];
        for (int i = 0; i < 4; i++) begin
            q[i] = round_shift(a[i] * 65536 + t * (b[i] - a[i]), 2);
            n += longint'(q[i] * q[i]);
        end
        res.degen = (n < 64'd7205760);
        if (res.degen) begin
            u[0] = 0; u[1] = 0; u[2] = 0; u[3] = 16384;
        end else begin
            for (int i = 0; i < 4; i++) u[i] = round_div(q[i] * 16384, int_sqrt(n));
        end
        x = u[0]; y = u[1]; z = u[2]; ww = u[3];
        r[0] = (longint'(1) << 28) - 2 * (y*y + z*z);
        r[1] = 2 * (x*y - z*ww);
        r[2] = 2 * (x*z + y*ww);
        r[3] = 2 * (x*y + z*ww);
        r[4] = (longint'(1) << 28) - 2 * (x*x + z*z);
        r[5] = 2 * (y*z - x*ww);
        r[6] = 2 * (x*z - y*ww);
        r[7] = 2 * (y*z + x*ww);
        r[8] = (longint'(1) << 28) - 2 * (x*x + y*y);
        for (int i = 0; i < 9; i++) begin
            v = round_shift(r[i] * s[i / 3], 22);
            if (v > 8388607) v = 8388607;
            if (v < -8388608) v = -8388608;
            res.elem[i] = v[23:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %0s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        matrices_seen = 0;
        degenerate_seen = 0;
    end

    assign pending = expected_matrices.size();

    // predict on input words, compare on output words
    always @(posedge aclk) begin
        matrix_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) expected_matrices.push_back(blend_to_matrix(s_tdata));
            if (m_tvalid && m_tready) begin
                matrices_seen++;
                if (m_tuser) degenerate_seen++;
                if (expected_matrices.size() == 0) begin
                    report_mismatch("unexpected word", 1, 0);
                end else begin
                    want = expected_matrices.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (m_tdata[24*i +: 24] !== want.elem[i])
                            report_mismatch($sformatf("element %0d", i),
                                            $signed(m_tdata[24*i +: 24]),
                                            $signed(want.elem[i]));
                    if (m_tuser !== want.degen)
                        report_mismatch("degenerate", m_tuser, want.degen);
                end
            end
        end
    end

endmodule

`default_nettype wire

/* verif/quaternion_blend_to_matrix_test.sv */
`default_nettype none

module quaternion_blend_to_matrix_test;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [199:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [215:0] m_tdata;
    logic         m_tuser;
    int           fail_count, pending, matrices_seen, degenerate_seen;
    int           cycle_count;
    int           send_idle_pct, recv_stall_pct;

    quaternion_blend_to_matrix u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    quaternion_blend_to_matrix_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending),
        .matrices_seen(matrices_seen), .degenerate_seen(degenerate_seen)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // cycle limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAIL quaternion_blend_to_matrix");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [199:0] pack_word(logic [3:0][15:0] qa, logic [3:0][15:0] qb,
                                               logic [16:0] t, logic [2:0][15:0] scl);
        return {7'd0, scl, t, qb, qa};
    endfunction

    // one word through the handshake, with optional idle before it
    task automatic send_word(logic [199:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_comp(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(16384)) - 16'sd8192);
            default: return 16'($urandom_range(32767, 0) - 16384);
        endcase
    endfunction

    // random keyframe pair: mostly components in [-1, 1), some full-range noise, some nearly opposite
    function automatic logic [199:0] rand_word();
        logic [3:0][15:0] qa, qb;
        logic [2:0][15:0] scl;
        logic [16:0]      t;
        int kind;
        kind = $urandom_range(9);
        for (int i = 0; i < 4; i++) begin
            qa[i] = rand_comp(kind < 2 ? 0 : 2);
            qb[i] = (kind == 9) ? 16'(-$signed(qa[i]) + $signed(16'($urandom_range(3)))) :
                    rand_comp(kind < 2 ? 0 : 2);
        end
        case ($urandom_range(5))
            0: t = 17'($urandom);
            1: t = 17'd65536;
            2: t = 17'd0;
            default: t = 17'($urandom_range(65536));
        endcase
        for (int i = 0; i < 3; i++)
            scl[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512));
        return pack_word(qa, qb, t, scl);
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (70) @(posedge aclk);
    endtask

    initial begin
        logic [3:0][15:0] qa;
        logic [2:0][15:0] scl;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: identity, extremes, opposite pair, degenerate, t above one
        qa = {16'sd16384, 16'd0, 16'd0, 16'd0};
        scl = {16'sd256, 16'sd256, 16'sd256};
        send_word(pack_word(qa, qa, 17'd0, scl));
        send_word(pack_word(qa, {16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 17'd32768, scl));
        send_word(pack_word({4{16'h8000}}, {4{16'h7fff}}, 17'd65536, {3{16'h7fff}}));
        send_word(pack_word({4{16'h7fff}}, {4{16'h7fff}}, 17'h1ffff, {3{16'h8000}}));
        send_word(pack_word({4{16'h8000}}, {4{16'h8000}}, 17'd40000, {3{16'h8000}}));
        send_word(pack_word('0, '0, 17'd0, {3{16'h7fff}}));
        send_word(pack_word(qa, {16'hc000, 16'd0, 16'd0, 16'd0}, 17'd32768, scl));
        send_word(pack_word(qa, {16'h4000, 16'd1, 16'd0, 16'd0}, 17'd32768, scl));
        send_word(pack_word({16'd0, 16'd0, 16'sd11585, 16'sd11585},
                            {16'sd11585, 16'sd11585, 16'd0, 16'd0}, 17'd70000,
                            {16'hff00, 16'h0180, 16'h7fff}));
        send_word(pack_word({16'd3, 16'd0, 16'd0, 16'd0}, {16'd2, 16'd0, 16'd0, 16'd0},
                            17'd1, scl));
        send_word(pack_word(qa, {16'd0, 16'd0, 16'sd16384, 16'd0}, 17'd65535, scl));
        for (int i = 0; i < 8; i++) send_word(rand_word());
        // hold off until everything is back
        wait_drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 71 : 28) : 0;
            recv_stall_pct = (phase == 2) ? 71 : (phase == 3 ? 28 : 0);
            for (int i = 0; i < 420; i++) send_word(rand_word());
            s_tvalid <= 1'b0;
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drain();

        $display("covered %0d matrices, %0d degenerate, under four idle and stall mixes",
                 matrices_seen, degenerate_seen);
        if (fail_count == 0) begin
            $display("PASS quaternion_blend_to_matrix");
        end else begin
            $display("FAIL quaternion_blend_to_matrix");
        end
        $finish;
    end

endmodule

`default_nettype wire
